/* rtl/kmc_pkg.sv */
// Shared constants, command codes and register addresses for the k-means clustering engine.
package kmc_pkg;
  localparam int MAX_POINTS   = 1024;
  localparam int MAX_DIMS     = 8;
  localparam int MAX_CLUSTERS = 16;
  localparam int COORD_W      = 16;
  localparam int PIDX_W       = $clog2(MAX_POINTS);
  localparam int DIDX_W       = $clog2(MAX_DIMS);
  localparam int CIDX_W       = $clog2(MAX_CLUSTERS);
  localparam int CNT_W        = PIDX_W + 1;
  localparam int SUM_W        = COORD_W + PIDX_W + 1;
  localparam int QCNT_W       = $clog2(SUM_W + 1);

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_RUN      = 2'd1;
  localparam logic [1:0] CMD_RD_ASSIGN = 2'd2;
  localparam logic [1:0] CMD_RD_CENT  = 2'd3;

  localparam logic [1:0] REG_NUM_POINTS = 2'd0;
  localparam logic [1:0] REG_DIMS       = 2'd1;
  localparam logic [1:0] REG_CLUSTERS   = 2'd2;
  localparam logic [1:0] REG_MAX_ITER   = 2'd3;
endpackage

/* rtl/kmc_div.sv */
// Restoring divider: one quotient bit per cycle, unsigned.
module kmc_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [kmc_pkg::SUM_W-1:0] dividend,
  input  logic [kmc_pkg::CNT_W-1:0] divisor,
  output logic                     done,
  output logic [kmc_pkg::SUM_W-1:0] quotient
);
  import kmc_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]    rem_r;
  logic [SUM_W-1:0]    quo_r;
  logic [CNT_W-1:0]    dvs_r;
  logic [CNT_W:0]      rem_sh;
  logic [CNT_W:0]      rem_sub;

  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        if (!rem_sub[CNT_W]) begin
          rem_r <= rem_sub[CNT_W-1:0];
          quo_r <= {quo_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[CNT_W-1:0];
          quo_r <= {quo_r[SUM_W-2:0], 1'b0};
        end
        if (cnt_r == QCNT_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

/* rtl/kmeans_clustering_engine_top.sv */
// Top level of the k-means clustering engine: command port, sequencer, stores.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  in_      | start / busy              | command, coordinate, point/cluster/dim idx
//  out_     | out_valid strobe (1 cyc)  | read_value, iterations_done, changed, conv
//  config   | APB psel/penable/pwrite   | paddr[3:2] selects one of four registers
//
// A request is taken when start is high and busy low. A load's result strobes in
// the next cycle and the next request may enter at once; a read passes through
// S_RDW before its registered strobe. A run clears all 1024 assignment entries,
// seeds k*d centroids from the first k points, then per iteration assigns each
// point on the one shared multiplier, clears 128 sums, accumulates members and
// divides each centroid coordinate on the serial divider. After reset the same
// clearing pass runs with busy high. The result strobe cannot be stalled.
module kmeans_clustering_engine_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_command,
  input  logic signed [kmc_pkg::COORD_W-1:0] in_coordinate,
  input  logic [kmc_pkg::PIDX_W-1:0]  in_point_index,
  input  logic [kmc_pkg::CIDX_W-1:0]  in_cluster_index,
  input  logic [kmc_pkg::DIDX_W-1:0]  in_dim_index,
  output logic                        out_valid,
  output logic signed [kmc_pkg::COORD_W-1:0] out_read_value,
  output logic [15:0]                 out_iterations_done,
  output logic [kmc_pkg::CNT_W-1:0]   out_changed_last,
  output logic                        out_converged,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import kmc_pkg::*;

  localparam logic [4:0] S_ACLR  = 5'd0,  S_IDLE  = 5'd1,  S_RDW   = 5'd2,
                         S_SEEDR = 5'd3,  S_SEEDW = 5'd4,  S_ARD   = 5'd5,
                         S_AMUL  = 5'd6,  S_AACC  = 5'd7,  S_AARD  = 5'd8,
                         S_AAWR  = 5'd9,  S_AEND  = 5'd10, S_UCLR  = 5'd11,
                         S_UARD  = 5'd12, S_UAQ   = 5'd13, S_UPRD  = 5'd14,
                         S_UPWR  = 5'd15, S_UDSEL = 5'd16, S_USRD  = 5'd17,
                         S_USLD  = 5'd18, S_UDWT  = 5'd19, S_FIN   = 5'd20;

  localparam int DIST_W = 2 * (COORD_W + 1) + DIDX_W;
  localparam logic [CIDX_W:0] NONE = {1'b1, {CIDX_W{1'b0}}};

  // configuration
  logic [CNT_W-1:0]  n_r;
  logic [DIDX_W:0]   d_r;
  logic [CIDX_W:0]   k_r;
  logic [15:0]       maxit_r;
  logic [CNT_W-1:0]  n_c;
  logic [DIDX_W:0]   d_c;
  logic [CIDX_W:0]   k_c;

  // sequencer
  logic [4:0]        state_r;
  logic              run_r;
  logic [1:0]        cmd_r;
  logic [PIDX_W-1:0] i_r;
  logic [CIDX_W-1:0] c_r;
  logic [CIDX_W-1:0] cl_r;
  logic [DIDX_W-1:0] j_r;
  logic [15:0]       iter_r;
  logic [CNT_W-1:0]  changed_r;
  logic              conv_r;
  logic [DIST_W-1:0] acc_r;
  logic [DIST_W-1:0] best_r;
  logic [CIDX_W-1:0] bestc_r;
  logic [2*(COORD_W+1)-1:0] mul_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r [MAX_CLUSTERS];

  // status and output
  logic [15:0]       last_iter_r;
  logic [CNT_W-1:0]  last_chg_r;
  logic              last_conv_r;
  logic              out_valid_r;
  logic signed [COORD_W-1:0] rv_r;

  // stores
  logic signed [COORD_W-1:0] pt_mem [MAX_POINTS*MAX_DIMS];
  logic signed [COORD_W-1:0] ce_mem [MAX_CLUSTERS*MAX_DIMS];
  logic [CIDX_W:0]           as_mem [MAX_POINTS];
  logic signed [SUM_W-1:0]   sm_mem [MAX_CLUSTERS*MAX_DIMS];
  logic signed [COORD_W-1:0] pt_q, ce_q;
  logic [CIDX_W:0]           as_q;
  logic signed [SUM_W-1:0]   sm_q;

  logic [PIDX_W+DIDX_W-1:0]  pt_ra, pt_wa;
  logic                      pt_we;
  logic [CIDX_W+DIDX_W-1:0]  ce_ra, ce_wa;
  logic                      ce_we;
  logic signed [COORD_W-1:0] ce_wd;
  logic [PIDX_W-1:0]         as_ra;
  logic                      as_we;
  logic [CIDX_W:0]           as_wd;
  logic [CIDX_W+DIDX_W-1:0]  sm_a;
  logic                      sm_we;
  logic signed [SUM_W-1:0]   sm_wd;

  logic signed [COORD_W:0]   diff;
  logic signed [2*(COORD_W+1)-1:0] sq;
  logic [DIST_W-1:0]         dist_sum;
  logic                      accept;
  logic                      cfg_wr;
  logic                      last_j, last_c, last_i;

  logic                      div_start, div_done;
  logic [SUM_W-1:0]          div_dvd, div_quo;
  logic signed [COORD_W-1:0] div_res;

  kmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (cnt_r[c_r]),
    .done     (div_done),
    .quotient (div_quo)
  );

  // clamp registers to legal ranges
  always_comb begin
    n_c = n_r;
    if (n_r == '0) n_c = CNT_W'(1);
    else if (n_r > CNT_W'(MAX_POINTS)) n_c = CNT_W'(MAX_POINTS);
    d_c = d_r;
    if (d_r == '0) d_c = (DIDX_W+1)'(1);
    else if (d_r > (DIDX_W+1)'(MAX_DIMS)) d_c = (DIDX_W+1)'(MAX_DIMS);
    k_c = k_r;
    if (k_r == '0) k_c = (CIDX_W+1)'(1);
    else if (k_r > (CIDX_W+1)'(MAX_CLUSTERS)) k_c = (CIDX_W+1)'(MAX_CLUSTERS);
  end

  assign last_j = ({1'b0, j_r} == d_c - 1'b1);
  assign last_c = ({1'b0, c_r} == k_c - 1'b1);
  assign last_i = ({1'b0, i_r} == n_c - 1'b1);

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // APB
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_NUM_POINTS: prdata = 32'(n_r);
      REG_DIMS:       prdata = 32'(d_r);
      REG_CLUSTERS:   prdata = 32'(k_r);
      REG_MAX_ITER:   prdata = 32'(maxit_r);
      default:        prdata = '0;
    endcase
  end

  // datapath
  assign diff     = (COORD_W+1)'(pt_q) - (COORD_W+1)'(ce_q);
  assign sq       = diff * diff;
  assign dist_sum = acc_r + DIST_W'(mul_r);
  // magnitude of the sum goes to the divider; sign taken straight from the read
  assign div_dvd  = sm_q[SUM_W-1] ? SUM_W'(-sm_q) : SUM_W'(sm_q);
  assign div_res  = neg_r ? COORD_W'(-div_quo) : COORD_W'(div_quo);
  assign div_start = (state_r == S_USLD);

  // store addressing
  always_comb begin
    pt_we = accept && (in_command == CMD_LOAD);
    pt_wa = {in_point_index, in_dim_index};
    pt_ra = (state_r == S_SEEDR) ? {PIDX_W'(c_r), j_r} : {i_r, j_r};
    ce_ra = (state_r == S_IDLE) ? {in_cluster_index, in_dim_index} : {c_r, j_r};
    ce_wa = {c_r, j_r};
    ce_we = (state_r == S_SEEDW) || (state_r == S_UDWT && div_done);
    ce_wd = (state_r == S_SEEDW) ? pt_q : div_res;
    as_ra = (state_r == S_IDLE) ? in_point_index : i_r;
    as_we = (state_r == S_ACLR) || (state_r == S_AAWR && as_q != {1'b0, bestc_r});
    as_wd = (state_r == S_ACLR) ? NONE : {1'b0, bestc_r};
    sm_a  = (state_r == S_UPRD || state_r == S_UPWR) ? {cl_r, j_r} : {c_r, j_r};
    sm_we = (state_r == S_UCLR) || (state_r == S_UPWR);
    sm_wd = (state_r == S_UCLR) ? '0 : sm_q + SUM_W'(pt_q);
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_wa] <= in_coordinate;
    pt_q <= pt_mem[pt_ra];
  end

  always_ff @(posedge clk) begin
    if (ce_we) ce_mem[ce_wa] <= ce_wd;
    ce_q <= ce_mem[ce_ra];
  end

  always_ff @(posedge clk) begin
    if (as_we) as_mem[i_r] <= as_wd;
    as_q <= as_mem[as_ra];
  end

  always_ff @(posedge clk) begin
    if (sm_we) sm_mem[sm_a] <= sm_wd;
    sm_q <= sm_mem[sm_a];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACLR;
      run_r       <= 1'b0;
      i_r         <= '0;
      c_r         <= '0;
      j_r         <= '0;
      n_r         <= CNT_W'(MAX_POINTS);
      d_r         <= (DIDX_W+1)'(2);
      k_r         <= (CIDX_W+1)'(4);
      maxit_r     <= 16'd100;
      last_iter_r <= '0;
      last_chg_r  <= '0;
      last_conv_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int q = 0; q < MAX_CLUSTERS; q++) cnt_r[q] <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_NUM_POINTS: n_r     <= pwdata[CNT_W-1:0];
          REG_DIMS:       d_r     <= pwdata[DIDX_W:0];
          REG_CLUSTERS:   k_r     <= pwdata[CIDX_W:0];
          REG_MAX_ITER:   maxit_r <= pwdata[15:0];
          default: ;
        endcase
      end
      case (state_r)
        S_ACLR: begin
          i_r <= i_r + 1'b1;
          if (i_r == PIDX_W'(MAX_POINTS - 1)) begin
            c_r <= '0;
            j_r <= '0;
            state_r <= run_r ? S_SEEDR : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r <= in_command;
            case (in_command)
              CMD_LOAD: begin
                out_valid_r <= 1'b1;
                rv_r <= '0;
              end
              CMD_RUN: begin
                run_r <= 1'b1;
                i_r <= '0;
                state_r <= S_ACLR;
              end
              default: state_r <= S_RDW;
            endcase
          end
        end
        S_RDW: begin
          out_valid_r <= 1'b1;
          if (cmd_r == CMD_RD_ASSIGN)
            rv_r <= as_q[CIDX_W] ? '1 : COORD_W'(as_q);
          else
            rv_r <= ce_q;
          state_r <= S_IDLE;
        end
        S_SEEDR: state_r <= S_SEEDW;
        S_SEEDW: begin
          if (last_j) begin
            j_r <= '0;
            if (last_c) begin
              c_r       <= '0;
              i_r       <= '0;
              iter_r    <= '0;
              changed_r <= '0;
              conv_r    <= 1'b0;
              acc_r     <= '0;
              state_r   <= (maxit_r == '0) ? S_FIN : S_ARD;
            end else begin
              c_r <= c_r + 1'b1;
              state_r <= S_SEEDR;
            end
          end else begin
            j_r <= j_r + 1'b1;
            state_r <= S_SEEDR;
          end
        end
        // assignment pass: each squared difference goes through S_ARD, S_AMUL and S_AACC
        S_ARD: state_r <= S_AMUL;
        S_AMUL: begin
          mul_r <= sq;
          state_r <= S_AACC;
        end
        S_AACC: begin
          if (last_j) begin
            if (c_r == '0 || dist_sum < best_r) begin
              best_r  <= dist_sum;
              bestc_r <= c_r;
            end
            acc_r <= '0;
            j_r   <= '0;
            if (last_c) begin
              c_r <= '0;
              state_r <= S_AARD;
            end else begin
              c_r <= c_r + 1'b1;
              state_r <= S_ARD;
            end
          end else begin
            acc_r <= dist_sum;
            j_r <= j_r + 1'b1;
            state_r <= S_ARD;
          end
        end
        S_AARD: state_r <= S_AAWR;
        S_AAWR: begin
          if (as_q != {1'b0, bestc_r}) changed_r <= changed_r + 1'b1;
          if (last_i) begin
            state_r <= S_AEND;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= S_ARD;
          end
        end
        S_AEND: begin
          iter_r <= iter_r + 1'b1;
          c_r <= '0;
          j_r <= '0;
          if (changed_r == '0) begin
            conv_r <= 1'b1;
            state_r <= S_FIN;
          end else begin
            for (int q = 0; q < MAX_CLUSTERS; q++) cnt_r[q] <= '0;
            state_r <= S_UCLR;
          end
        end
        // update pass: clear sums, accumulate members, divide
        S_UCLR: begin
          {c_r, j_r} <= {c_r, j_r} + 1'b1;
          if ({c_r, j_r} == '1) begin
            i_r <= '0;
            state_r <= S_UARD;
          end
        end
        S_UARD: state_r <= S_UAQ;
        S_UAQ: begin
          cl_r <= as_q[CIDX_W-1:0];
          cnt_r[as_q[CIDX_W-1:0]] <= cnt_r[as_q[CIDX_W-1:0]] + 1'b1;
          j_r <= '0;
          state_r <= S_UPRD;
        end
        S_UPRD: state_r <= S_UPWR;
        S_UPWR: begin
          if (last_j) begin
            j_r <= '0;
            if (last_i) begin
              c_r <= '0;
              state_r <= S_UDSEL;
            end else begin
              i_r <= i_r + 1'b1;
              state_r <= S_UARD;
            end
          end else begin
            j_r <= j_r + 1'b1;
            state_r <= S_UPRD;
          end
        end
        S_UDSEL: begin
          j_r <= '0;
          if (cnt_r[c_r] != '0) begin
            state_r <= S_USRD;
          end else if (last_c) begin
            c_r <= '0;
            i_r <= '0;
            acc_r <= '0;
            // keep the change count when the limit ends the run
            if (iter_r >= maxit_r) begin
              state_r <= S_FIN;
            end else begin
              changed_r <= '0;
              state_r <= S_ARD;
            end
          end else begin
            c_r <= c_r + 1'b1;
          end
        end
        S_USRD: state_r <= S_USLD;
        S_USLD: begin
          neg_r <= sm_q[SUM_W-1];
          state_r <= S_UDWT;
        end
        S_UDWT: begin
          if (div_done) begin
            if (!last_j) begin
              j_r <= j_r + 1'b1;
              state_r <= S_USRD;
            end else if (last_c) begin
              j_r <= '0;
              c_r <= '0;
              i_r <= '0;
              acc_r <= '0;
              if (iter_r >= maxit_r) begin
                state_r <= S_FIN;
              end else begin
                changed_r <= '0;
                state_r <= S_ARD;
              end
            end else begin
              j_r <= '0;
              c_r <= c_r + 1'b1;
              state_r <= S_UDSEL;
            end
          end
        end
        S_FIN: begin
          last_iter_r <= iter_r;
          last_chg_r  <= changed_r;
          last_conv_r <= conv_r;
          out_valid_r <= 1'b1;
          rv_r        <= '0;
          run_r       <= 1'b0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_value      = rv_r;
  assign out_iterations_done = last_iter_r;
  assign out_changed_last    = last_chg_r;
  assign out_converged       = last_conv_r;
endmodule
